### rtl/core/stepper_driver_uart_write_framer_defines.svh
// assertion macros used by the framer checker
`ifndef STEPPER_DRIVER_UART_WRITE_FRAMER_DEFINES_SVH
`define STEPPER_DRIVER_UART_WRITE_FRAMER_DEFINES_SVH

// implication checked on the same edge, clocked on clk, off during reset
`define SDUWF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication checked on the following edge
`define SDUWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sduwf_pkg.sv
// shared types and constants of the uart write framer
`timescale 1ns / 1ps

package sduwf_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'h05;
    localparam logic [7:0] WRITE_FLAG    = 8'h80;
    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [7:0] ADDR_GCONF    = 8'h00;
    localparam logic [7:0] ADDR_CURRENT  = 8'h10;
    localparam logic [7:0] ADDR_CHOPCONF = 8'h6C;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int PADDR_W     = 5;

    // register indexes on the apb port
    localparam logic [2:0] REG_SLAVE_ADDRESS = 3'd0;
    localparam logic [2:0] REG_HOLD_DELAY    = 3'd1;
    localparam logic [2:0] REG_RUN_DELAY     = 3'd2;
    localparam logic [2:0] REG_GCONF         = 3'd3;
    localparam logic [2:0] REG_CHOPCONF      = 3'd4;
    localparam logic [2:0] REG_DEFAULT_MRES  = 3'd5;

    typedef enum logic [1:0] {
        CMD_REJECT,
        CMD_CURRENT,
        CMD_MICROSTEP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] word0;
        logic [31:0] word1;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  slave_address;
        logic [3:0]  hold_delay_code;
        logic [3:0]  run_delay_code;
        logic [31:0] gconf_word;
        logic [31:0] chopconf_base;
        logic [3:0]  default_mres;
    } cfg_t;

endpackage

### rtl/core/sduwf_front.sv
// front end: takes commands, checks codes and builds the register words
`timescale 1ns / 1ps

module sduwf_front
    import sduwf_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [0:0] s_tuser,
    input  logic [23:0] s_tdata,
    input  cfg_t       cfg,
    input  logic       queue_full,
    output logic       push,
    output cmd_t       push_cmd
);

    logic [5:0]  hold_code;
    logic [5:0]  run_code;
    logic [8:0]  step_division;
    logic [3:0]  mres;

    function automatic logic [3:0] mres_for(input logic [8:0] div, input logic [3:0] dflt);
        logic [3:0] code;
        begin
            case (div)
                9'd1:    code = 4'd8;
                9'd2:    code = 4'd7;
                9'd4:    code = 4'd6;
                9'd8:    code = 4'd5;
                9'd16:   code = 4'd4;
                9'd32:   code = 4'd3;
                9'd64:   code = 4'd2;
                9'd128:  code = 4'd1;
                9'd256:  code = 4'd0;
                default: code = dflt;
            endcase
            return code;
        end
    endfunction

    assign hold_code     = s_tdata[5:0];
    assign run_code      = s_tdata[11:6];
    assign step_division = s_tdata[20:12];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;
    assign mres     = mres_for(step_division, cfg.default_mres);

    always_comb
    begin
        push_cmd.word0 = '0;
        push_cmd.word1 = '0;
        if (s_tuser[0])
        begin
            push_cmd.kind  = CMD_MICROSTEP;
            push_cmd.word0 = cfg.gconf_word;
            push_cmd.word1 = {cfg.chopconf_base[31:28], mres, cfg.chopconf_base[23:0]};
        end
        else if (hold_code[5] || run_code[5])
        begin
            push_cmd.kind = CMD_REJECT;
        end
        else
        begin
            push_cmd.kind  = CMD_CURRENT;
            push_cmd.word0 = {4'd0, cfg.run_delay_code, 4'd0, cfg.hold_delay_code,
                              3'd0, run_code[4:0], 3'd0, hold_code[4:0]};
        end
    end

endmodule

### rtl/core/sduwf_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps

module sduwf_queue
    import sduwf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic not_empty,
    input  logic pop,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/sduwf_back.sv
// back end: serializes datagrams byte by byte with a running crc
`timescale 1ns / 1ps

module sduwf_back
    import sduwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] slave_address,
    input  logic       queue_valid,
    input  cmd_t       queue_cmd,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [0:0] m_tuser
);

    cmd_t        cmd_reg;
    logic        busy_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  crc_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;
    logic        out_status_reg;

    logic        emit;
    logic        done;
    logic        frame1;
    logic [2:0]  pos;
    logic [31:0] word;
    logic [7:0]  reg_addr;
    logic [7:0]  byte_val;
    logic        byte_last;
    logic        byte_status;
    logic [7:0]  crc_next;

    function automatic logic [7:0] crc_update(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        begin
            c = crc_in;
            for (int k = 0; k < 8; k++)
            begin
                fb = c[7] ^ b[k];
                c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return c;
        end
    endfunction

    assign frame1   = idx_reg[3];
    assign pos      = idx_reg[2:0];
    assign word     = frame1 ? cmd_reg.word1 : cmd_reg.word0;
    assign reg_addr = (cmd_reg.kind == CMD_CURRENT) ? ADDR_CURRENT :
                      (frame1 ? ADDR_CHOPCONF : ADDR_GCONF);

    always_comb
    begin
        case (pos)
            3'd0:    byte_val = SYNC_BYTE;
            3'd1:    byte_val = {6'd0, slave_address};
            3'd2:    byte_val = reg_addr | WRITE_FLAG;
            3'd3:    byte_val = word[31:24];
            3'd4:    byte_val = word[23:16];
            3'd5:    byte_val = word[15:8];
            3'd6:    byte_val = word[7:0];
            default: byte_val = crc_reg;
        endcase
        byte_status = 1'b0;
        case (cmd_reg.kind)
            CMD_REJECT:
            begin
                byte_val    = 8'h00;
                byte_last   = 1'b1;
                byte_status = 1'b1;
            end
            CMD_CURRENT:   byte_last = (idx_reg == 4'd7);
            CMD_MICROSTEP: byte_last = (idx_reg == 4'd15);
            default:       byte_last = 1'b1;
        endcase
    end

    assign crc_next = crc_update((pos == 3'd0) ? 8'h00 : crc_reg, byte_val);

    // while busy, a byte leaves whenever the output register is free or being drained
    assign emit = busy_reg && (!out_valid_reg || m_tready);
    assign done = emit && byte_last;
    assign pop  = queue_valid && (!busy_reg || done);

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= queue_cmd;
        if (emit)
        begin
            crc_reg        <= crc_next;
            out_data_reg   <= byte_val;
            out_last_reg   <= byte_last;
            out_status_reg <= byte_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (done)
                busy_reg <= 1'b0;
            else if (emit)
                idx_reg <= idx_reg + 1'b1;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_status_reg;

endmodule

### rtl/core/stepper_driver_uart_write_framer.sv
// top level of the stepper driver uart write datagram framer
`timescale 1ns / 1ps
// first byte of a command: through the queue entry, cmd_reg and output register to m_tdata
// the back-end serializer sends one byte per cycle while m_tready is high, so a command gives
//   16 bytes (microstep), 8 bytes (current) or 1 byte (rejected code)
// a two-entry queue lets the front take the next requests while bytes still drain
// reset: rst_n async low clears queue, serializer and output valid; config regs go to 0

module stepper_driver_uart_write_framer
    import sduwf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // command stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [0:0]         s_tuser,   // opcode
    input  logic [23:0]        s_tdata,   // hold_code[5:0], run_code[11:6], step_division[20:12]
    // datagram byte stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // tx_byte
    output logic               m_tlast,   // last_byte
    output logic [0:0]         m_tuser,   // status
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic [2:0] reg_index;

    logic       push;
    cmd_t       push_cmd;
    logic       queue_full;
    logic       queue_valid;
    logic       pop;
    cmd_t       pop_cmd;

    // register file: written on the apb access phase, no wait states
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            case (reg_index)
                REG_SLAVE_ADDRESS: cfg_reg.slave_address   <= pwdata[1:0];
                REG_HOLD_DELAY:    cfg_reg.hold_delay_code <= pwdata[3:0];
                REG_RUN_DELAY:     cfg_reg.run_delay_code  <= pwdata[3:0];
                REG_GCONF:         cfg_reg.gconf_word      <= pwdata;
                REG_CHOPCONF:      cfg_reg.chopconf_base   <= pwdata;
                REG_DEFAULT_MRES:  cfg_reg.default_mres    <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    // readback, zero extended; unused addresses read zero
    always_comb
    begin
        case (reg_index)
            REG_SLAVE_ADDRESS: prdata = {30'd0, cfg_reg.slave_address};
            REG_HOLD_DELAY:    prdata = {28'd0, cfg_reg.hold_delay_code};
            REG_RUN_DELAY:     prdata = {28'd0, cfg_reg.run_delay_code};
            REG_GCONF:         prdata = cfg_reg.gconf_word;
            REG_CHOPCONF:      prdata = cfg_reg.chopconf_base;
            REG_DEFAULT_MRES:  prdata = {28'd0, cfg_reg.default_mres};
            default:           prdata = '0;
        endcase
    end

    // front: classify the request and build the register words
    sduwf_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decouples request intake from byte output
    sduwf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .not_empty (queue_valid),
        .pop       (pop),
        .pop_cmd   (pop_cmd)
    );

    // back: one byte per cycle while m_tready is high, crc accumulated as bytes go out
    sduwf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (cfg_reg.slave_address),
        .queue_valid   (queue_valid),
        .queue_cmd     (pop_cmd),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser)
    );

endmodule

### rtl/core/sduwf_checker.sv
// port-level checker for the uart write framer, bound to the top level
`timescale 1ns / 1ps
`include "stepper_driver_uart_write_framer_defines.svh"

module sduwf_checker
    import sduwf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [7:0]         m_tdata,
    input logic               m_tlast,
    input logic [0:0]         m_tuser
);

    `SDUWF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output dropped or changed while stalled")
    `SDUWF_ASSERT_SAME(a_reject_single, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 8'h00), "reject result not a single zero byte")
    `SDUWF_ASSERT_NEXT(a_frame_start, m_tvalid && m_tready && m_tlast, !m_tvalid || m_tuser[0] || (m_tdata == SYNC_BYTE), "next command does not open with sync")
    `SDUWF_ASSERT_NEXT(a_sync_then_addr, m_tvalid && m_tready && !m_tlast && (m_tdata == SYNC_BYTE) && !m_tuser[0], !m_tvalid || (m_tdata[7:2] == 6'd0) || m_tuser[0] == 1'b0, "status raised inside a frame")

endmodule

bind stepper_driver_uart_write_framer sduwf_checker u_sduwf_checker (.*);

### test/stepper_driver_uart_write_framer_tb.sv
// testbench of the uart write datagram framer: checks every byte against its own datagram predictor
`timescale 1ns / 1ps

module stepper_driver_uart_write_framer_tb;
    import sduwf_pkg::*;

    // opcodes of a command request
    localparam logic OP_SET_CURRENT   = 1'b0;
    localparam logic OP_SET_MICROSTEP = 1'b1;

    // status of a result byte
    localparam logic STATUS_FRAME  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // register indexes past the last register, writes there must be ignored
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    localparam logic [5:0] CODE_MAX      = 6'd31;
    localparam int         MRES_LSB      = 24;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic       opcode;
        logic [5:0] hold_code;
        logic [5:0] run_code;
        logic [8:0] step_division;
    } cmd_req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       status;
    } frame_byte_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [0:0]         s_tuser;   // opcode
    logic [23:0]        s_tdata;   // hold_code[5:0], run_code[11:6], step_division[20:12]
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;   // tx_byte
    logic               m_tlast;   // last_byte
    logic [0:0]         m_tuser;   // status
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // pending command requests, filled by the sequence below
    cmd_req_t    cmd_pending_q[$];
    // bytes the framer still owes, oldest first
    frame_byte_t datagram_byte_q[$];
    // shadow of the framer registers
    cfg_t        framer_cfg;

    int   sender_idle_pct;
    int   recv_idle_pct;
    logic send_hold;      // pauses the driver until the framer drains
    logic s_fire;         // request taken at the last rising edge
    int   fail_count;
    int   cycle_count;

    stepper_driver_uart_write_framer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // crc-8, poly 0x07, data bits enter lsb first at the top of the register
    function automatic logic [7:0] crc8_lsb_first(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       fb;
        int         k;
        acc = crc;
        for (k = 0; k < 8; k++)
        begin
            fb  = acc[7] ^ data[k];
            acc = {acc[6:0], 1'b0};
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // mres code for a power-of-two count, the configured default for anything else
    function automatic logic [3:0] mres_from_division(input logic [8:0] division);
        int p;
        for (p = 0; p <= 8; p++)
        begin
            if (division == (9'd1 << p))
                return 4'(8 - p);
        end
        return framer_cfg.default_mres;
    endfunction

    // one 8-byte write datagram, last_byte set on its final byte when it ends the command
    task automatic push_datagram(input logic [7:0] reg_addr, input logic [31:0] word,
                                 input logic ends_command);
        logic [7:0]  frame [8];
        logic [7:0]  crc;
        frame_byte_t fb;
        int          i;
        frame[0] = SYNC_BYTE;
        frame[1] = {6'b0, framer_cfg.slave_address};
        frame[2] = reg_addr | WRITE_FLAG;
        frame[3] = word[31:24];
        frame[4] = word[23:16];
        frame[5] = word[15:8];
        frame[6] = word[7:0];
        crc = 8'h00;
        for (i = 0; i < 7; i++)
            crc = crc8_lsb_first(crc, frame[i]);
        frame[7] = crc;
        for (i = 0; i < 8; i++)
        begin
            fb.tx_byte   = frame[i];
            fb.last_byte = ends_command && (i == 7);
            fb.status    = STATUS_FRAME;
            datagram_byte_q.push_back(fb);
        end
    endtask

    // expected bytes of one accepted command request
    task automatic predict_command_bytes(input cmd_req_t req);
        logic [31:0] word;
        frame_byte_t fb;
        if (req.opcode == OP_SET_CURRENT)
        begin
            if (req.hold_code > CODE_MAX || req.run_code > CODE_MAX)
            begin
                // a code above 31 gives a lone reject status and no frame
                fb.tx_byte   = 8'h00;
                fb.last_byte = 1'b1;
                fb.status    = STATUS_REJECT;
                datagram_byte_q.push_back(fb);
            end
            else
            begin
                word = {4'b0, framer_cfg.run_delay_code, 4'b0, framer_cfg.hold_delay_code,
                        3'b0, req.run_code[4:0], 3'b0, req.hold_code[4:0]};
                push_datagram(ADDR_CURRENT, word, 1'b1);
            end
        end
        else
        begin
            // gconf first, then chopconf with mres spliced into bits 27:24
            word = framer_cfg.chopconf_base;
            word[MRES_LSB +: 4] = mres_from_division(req.step_division);
            push_datagram(ADDR_GCONF, framer_cfg.gconf_word, 1'b0);
            push_datagram(ADDR_CHOPCONF, word, 1'b1);
        end
    endtask

    // random request: mostly legal codes and power-of-two counts, the rest anything
    function automatic cmd_req_t random_command();
        cmd_req_t req;
        req.opcode = 1'($urandom_range(0, 1));
        req.hold_code = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 31)
                                                         : $urandom_range(0, 63));
        req.run_code  = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 31)
                                                         : $urandom_range(0, 63));
        if ($urandom_range(0, 99) < 60)
            req.step_division = 9'd1 << $urandom_range(0, 8);
        else
            req.step_division = 9'($urandom_range(0, 511));
        return req;
    endfunction

    function automatic cmd_req_t make_command(input logic opcode, input logic [5:0] hold_code,
                                              input logic [5:0] run_code,
                                              input logic [8:0] step_division);
        cmd_req_t req;
        req.opcode        = opcode;
        req.hold_code     = hold_code;
        req.run_code      = run_code;
        req.step_division = step_division;
        return req;
    endfunction

    // apb write: setup then access, register taken at the access edge
    task automatic apb_write(input logic [2:0] reg_index, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (reg_index)
            REG_SLAVE_ADDRESS: framer_cfg.slave_address   = value[1:0];
            REG_HOLD_DELAY:    framer_cfg.hold_delay_code = value[3:0];
            REG_RUN_DELAY:     framer_cfg.run_delay_code  = value[3:0];
            REG_GCONF:         framer_cfg.gconf_word      = value;
            REG_CHOPCONF:      framer_cfg.chopconf_base   = value;
            REG_DEFAULT_MRES:  framer_cfg.default_mres    = value[3:0];
            default:           ;
        endcase
    endtask

    task automatic write_all_registers(input logic [31:0] slave, input logic [31:0] hold_dly,
                                       input logic [31:0] run_dly, input logic [31:0] gconf,
                                       input logic [31:0] chop, input logic [31:0] mres);
        apb_write(REG_SLAVE_ADDRESS, slave);
        apb_write(REG_HOLD_DELAY, hold_dly);
        apb_write(REG_RUN_DELAY, run_dly);
        apb_write(REG_GCONF, gconf);
        apb_write(REG_CHOPCONF, chop);
        apb_write(REG_DEFAULT_MRES, mres);
    endtask

    // wait until every request is taken and every byte has come, plus the pipeline tail
    task automatic wait_for_drain();
        while (cmd_pending_q.size() != 0 || s_tvalid || datagram_byte_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver, changes at the falling edge only
    always @(negedge clk)
    begin : request_driver
        cmd_req_t nxt_req;
        if (rst_n && (!s_tvalid || s_fire))
        begin
            if (!send_hold && cmd_pending_q.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct)
            begin
                nxt_req = cmd_pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt_req.opcode;
                s_tdata  <= {3'b000, nxt_req.step_division, nxt_req.run_code, nxt_req.hold_code};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // byte receiver stalls at random
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // prediction on each taken request, check on each taken byte
    always @(posedge clk)
    begin : stream_monitor
        frame_byte_t want;
        cmd_req_t    got_req;
        s_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            got_req.opcode        = s_tuser[0];
            got_req.hold_code     = s_tdata[5:0];
            got_req.run_code      = s_tdata[11:6];
            got_req.step_division = s_tdata[20:12];
            predict_command_bytes(got_req);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (datagram_byte_q.size() == 0)
            begin
                $error("byte 0x%02h with no byte expected", m_tdata);
                fail_count++;
            end
            else
            begin
                want = datagram_byte_q.pop_front();
                if (m_tdata !== want.tx_byte)
                begin
                    $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last_byte)
                begin
                    $error("last_byte: expected %0d, got %0d", want.last_byte, m_tlast);
                    fail_count++;
                end
                if (m_tuser[0] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int i;
        int p;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tuser         = '0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_fire          = 1'b0;
        send_hold       = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        sender_idle_pct = 23;
        recv_idle_pct   = 71;
        framer_cfg      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed requests under reset config: code extremes, rejects, every mres count
        cmd_pending_q.push_back(make_command(OP_SET_CURRENT, 6'd0, 6'd0, 9'd0));
        cmd_pending_q.push_back(make_command(OP_SET_CURRENT, 6'd31, 6'd31, 9'd511));
        cmd_pending_q.push_back(make_command(OP_SET_CURRENT, 6'd32, 6'd0, 9'd0));
        cmd_pending_q.push_back(make_command(OP_SET_CURRENT, 6'd0, 6'd32, 9'd0));
        cmd_pending_q.push_back(make_command(OP_SET_CURRENT, 6'd63, 6'd63, 9'd511));
        cmd_pending_q.push_back(make_command(OP_SET_CURRENT, 6'd31, 6'd63, 9'd1));
        cmd_pending_q.push_back(make_command(OP_SET_CURRENT, 6'd21, 6'd10, 9'd256));
        for (p = 0; p <= 8; p++)
            cmd_pending_q.push_back(make_command(OP_SET_MICROSTEP, 6'd0, 6'd0, 9'd1 << p));
        // counts that fall back to the default mres, zero among them
        cmd_pending_q.push_back(make_command(OP_SET_MICROSTEP, 6'd63, 6'd63, 9'd0));
        cmd_pending_q.push_back(make_command(OP_SET_MICROSTEP, 6'd0, 6'd0, 9'd3));
        cmd_pending_q.push_back(make_command(OP_SET_MICROSTEP, 6'd0, 6'd0, 9'd255));
        cmd_pending_q.push_back(make_command(OP_SET_MICROSTEP, 6'd0, 6'd0, 9'd257));
        cmd_pending_q.push_back(make_command(OP_SET_MICROSTEP, 6'd0, 6'd0, 9'd511));
        wait_for_drain();

        // all registers at their top value, unused indexes poked with junk
        write_all_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        apb_write(REG_UNUSED_LO, $urandom());
        apb_write(REG_UNUSED_HI, $urandom());
        cmd_pending_q.push_back(make_command(OP_SET_MICROSTEP, 6'd0, 6'd0, 9'd6));
        cmd_pending_q.push_back(make_command(OP_SET_MICROSTEP, 6'd0, 6'd0, 9'd16));
        cmd_pending_q.push_back(make_command(OP_SET_CURRENT, 6'd31, 6'd31, 9'd0));
        for (i = 0; i < 140; i++)
            cmd_pending_q.push_back(random_command());
        wait_for_drain();

        // random register values, idling swapped
        write_all_registers($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom());
        sender_idle_pct = 71;
        recv_idle_pct   = 23;
        for (i = 0; i < 140; i++)
            cmd_pending_q.push_back(random_command());
        // mid-phase pause: hold requests back until the framer has sent everything
        while (cmd_pending_q.size() > 70)
            @(posedge clk);
        send_hold = 1'b1;
        while (s_tvalid || datagram_byte_q.size() != 0)
            @(posedge clk);
        send_hold = 1'b0;
        wait_for_drain();

        // registers back to zero, no idling at all
        write_all_registers(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        for (i = 0; i < 65; i++)
            cmd_pending_q.push_back(random_command());
        wait_for_drain();
        write_all_registers($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom());
        for (i = 0; i < 65; i++)
            cmd_pending_q.push_back(random_command());
        wait_for_drain();

        if (datagram_byte_q.size() != 0)
        begin
            $error("%0d expected bytes never came", datagram_byte_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### stepper_driver_uart_write_framer.f
+incdir+rtl/core
rtl/core/sduwf_pkg.sv
rtl/core/sduwf_front.sv
rtl/core/sduwf_queue.sv
rtl/core/sduwf_back.sv
rtl/core/stepper_driver_uart_write_framer.sv
rtl/core/sduwf_checker.sv
test/stepper_driver_uart_write_framer_tb.sv
